[hdl/mpf_pkg.sv]
// ----------------------------------------------------------------------------
// mpf_pkg
// Shared widths and mode codes of the page-mode monochrome framebuffer.
// ----------------------------------------------------------------------------
package mpf_pkg;

  localparam int MODE_W  = 2;
  localparam int COORD_W = 8;
  localparam int PAGE_W  = COORD_W - 3;
  localparam int BYTE_W  = 8;
  // page * width never needs more than this
  localparam int BASE_W  = PAGE_W + COORD_W + 1;

  localparam logic [MODE_W-1:0] MODE_DRAW = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FILL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

  localparam logic [BYTE_W-1:0] FILL_CLEAR = 8'h00;
  localparam logic [BYTE_W-1:0] FILL_SET   = 8'hFF;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_INVERT_PIXELS = 3'd0;

endpackage

[hdl/mpf_in_if.sv]
// ----------------------------------------------------------------------------
// mpf_in_if
// Command channel: draw, fill or read request.
// ----------------------------------------------------------------------------
interface mpf_in_if;
  import mpf_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;
  logic               color;

  modport source (output valid, output mode, output column, output row, output color,
                  input ready);
  modport sink   (input valid, input mode, input column, input row, input color,
                  output ready);
endinterface

[hdl/mpf_out_if.sv]
// ----------------------------------------------------------------------------
// mpf_out_if
// Response channel: read byte and range flag.
// ----------------------------------------------------------------------------
interface mpf_out_if;
  import mpf_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_byte;
  logic              in_range;

  modport source (output valid, output read_byte, output in_range, input ready);
  modport sink   (input valid, input read_byte, input in_range, output ready);
endinterface

[hdl/mpf_store.sv]
// ----------------------------------------------------------------------------
// mpf_store
// Frame byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mpf_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         waddr,
  input  logic [mpf_pkg::BYTE_W-1:0] wdata,
  input  logic                      re,
  input  logic [ADDR_W-1:0]         raddr,
  output logic [mpf_pkg::BYTE_W-1:0] rdata
);
  import mpf_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/mpf_ctrl.sv]
// ----------------------------------------------------------------------------
// mpf_ctrl
// Command sequencer: address math, read-modify-write of one byte, fill sweep
// and the response register.
// ----------------------------------------------------------------------------
module mpf_ctrl #(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 64,
  parameter int DEPTH          = 1024,
  parameter int ADDR_W         = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        invert_pixels,
  mpf_in_if.sink                      in_ch,
  mpf_out_if.source                   out_ch,
  output logic                        mem_we,
  output logic [ADDR_W-1:0]           mem_waddr,
  output logic [mpf_pkg::BYTE_W-1:0]  mem_wdata,
  output logic                        mem_re,
  output logic [ADDR_W-1:0]           mem_raddr,
  input  logic [mpf_pkg::BYTE_W-1:0]  mem_rdata
);
  import mpf_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_FILL, ST_RESP} state_t;

  localparam logic [COORD_W:0]  WIDTH_C   = (COORD_W + 1)'(DISPLAY_WIDTH);
  localparam logic [COORD_W:0]  HEIGHT_C  = (COORD_W + 1)'(DISPLAY_HEIGHT);
  localparam logic [BASE_W-1:0] WIDTH_B   = BASE_W'(DISPLAY_WIDTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  state_t            state_r, state_nxt;
  logic [MODE_W-1:0] mode_r;
  logic              ok_r;
  logic [2:0]        bit_r;
  logic              color_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] cnt_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_range_r;

  logic              accept;
  logic              coord_ok;
  logic              item_ok;
  logic [BASE_W-1:0] page_base;
  logic [ADDR_W-1:0] in_addr;
  logic              load_out;
  logic [BYTE_W-1:0] bit_mask;
  logic [BYTE_W-1:0] fill_byte;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign coord_ok  = ({1'b0, in_ch.column} < WIDTH_C) && ({1'b0, in_ch.row} < HEIGHT_C);
  assign page_base = BASE_W'(in_ch.row[COORD_W-1:3]) * WIDTH_B;
  assign in_addr   = ADDR_W'(in_ch.column) + ADDR_W'(page_base);

  always_comb begin
    case (in_ch.mode) inside
      MODE_DRAW, MODE_READ: item_ok = coord_ok;
      MODE_FILL:            item_ok = 1'b1;
      default:              item_ok = 1'b0;
    endcase
  end

  assign load_out  = (state_r == ST_RESP) && (!out_valid_r || out_ch.ready);
  assign bit_mask  = BYTE_W'(1) << bit_r;
  assign fill_byte = color_r ? FILL_SET : FILL_CLEAR;

  // store accesses
  assign mem_re    = accept;
  assign mem_raddr = in_addr;
  assign mem_waddr = (state_r == ST_FILL) ? cnt_r : addr_r;
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = fill_byte;
    if (state_r == ST_FILL) begin
      mem_we = 1'b1;
    end else if (load_out && mode_r == MODE_DRAW && ok_r) begin
      mem_we    = 1'b1;
      mem_wdata = color_r ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_ch.mode == MODE_FILL) ? ST_FILL : ST_RESP;
        end
      end
      ST_FILL: begin
        if (cnt_r == LAST_ADDR) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
        out_byte_r  <= (mode_r == MODE_READ && ok_r) ? mem_rdata : '0;
        out_range_r <= ok_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        mode_r  <= in_ch.mode;
        ok_r    <= item_ok;
        bit_r   <= in_ch.row[2:0];
        addr_r  <= in_addr;
        cnt_r   <= '0;
        // inversion applies to single-pixel draws only
        color_r <= (in_ch.mode == MODE_DRAW) ? (in_ch.color ^ invert_pixels) : in_ch.color;
      end else if (state_r == ST_FILL) begin
        cnt_r <= cnt_r + ADDR_W'(1);
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_byte = out_byte_r;
  assign out_ch.in_range  = out_range_r;

  a_store_write_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_FILL || state_r == ST_RESP))
    else $error("store written outside fill or response");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != ST_IDLE))
    else $error("accepted word did not start work");

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_range_r) |-> (out_byte_r == '0))
    else $error("nonzero byte on out-of-range response");

  a_fill_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL && cnt_r == LAST_ADDR) |=> (state_r == ST_RESP))
    else $error("fill sweep did not end at last byte");

endmodule

[hdl/mono_page_framebuffer.sv]
// ----------------------------------------------------------------------------
// mono_page_framebuffer
// Page-organized monochrome framebuffer with pixel draw, fill and byte read.
// ----------------------------------------------------------------------------
// Commands are handled one at a time. For a pixel draw or a byte read the
// byte is read from the frame store (one read port, one write port) in the
// accept cycle and, for a draw, written back with the pixel changed when
// the response is loaded into the output register.
// A fill sweeps the store one byte per cycle, writing all
// DISPLAY_WIDTH*ceil(DISPLAY_HEIGHT/8) bytes (1024 at 128x64). The
// response sits in an output register, so the next command is taken while
// it waits. The store is not cleared at reset; fill it before reading.
// invert_pixels lives at byte address 0 of the register port.
module mono_page_framebuffer #(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mpf_in_if.sink                          in_ch,
  mpf_out_if.source                       out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [mpf_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [mpf_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [mpf_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import mpf_pkg::*;

  localparam int PAGES  = (DISPLAY_HEIGHT + 7) / 8;
  localparam int DEPTH  = DISPLAY_WIDTH * PAGES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              invert_r;
  logic              reg_hit;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  // word index is paddr[2]; low bits ignored
  assign reg_hit    = (cfg_paddr[2] == REG_INVERT_PIXELS[2]);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_hit ? CFG_DATA_W'(invert_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit) begin
      invert_r <= cfg_pwdata[0];
    end
  end

  mpf_ctrl #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
    .DEPTH          (DEPTH),
    .ADDR_W         (ADDR_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .invert_pixels (invert_r),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  mpf_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

[bench/mpf_resp_check.sv]
// ----------------------------------------------------------------------------
// mpf_resp_check
// Watches the command, response and register channels of the framebuffer,
// keeps its own copy of the frame store and the invert bit, and compares
// every response word against the oldest predicted one.
// ----------------------------------------------------------------------------
module mpf_resp_check #(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mpf_in_if                              in_ch,
  mpf_out_if                             out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic                           cfg_pready,
  input  logic [mpf_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [mpf_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input  logic [mpf_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output int                             fail_count,
  output int                             pending_cnt,
  output int                             checked_cnt
);
  timeunit 1ns;
  timeprecision 1ps;
  import mpf_pkg::*;

  localparam int PAGES       = (DISPLAY_HEIGHT + 7) / 8;
  localparam int STORE_DEPTH = DISPLAY_WIDTH * PAGES;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [BYTE_W-1:0]  read_byte;
    logic               in_range;
  } pixel_resp_t;

  logic [BYTE_W-1:0] frame_copy [STORE_DEPTH];
  logic              invert_q;
  pixel_resp_t       expected_resp [$];
  int                fails;
  int                checked;

  // applies one command to the local frame copy and returns its response
  function automatic pixel_resp_t apply_command(input logic [MODE_W-1:0] mode,
                                                input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y,
                                                input logic color);
    pixel_resp_t r;
    logic        on_screen;
    int          addr;
    r           = '0;
    r.mode      = mode;
    r.column    = x;
    r.row       = y;
    on_screen   = (int'(x) < DISPLAY_WIDTH) && (int'(y) < DISPLAY_HEIGHT);
    addr        = int'(x) + int'(y >> 3) * DISPLAY_WIDTH;
    case (mode)
      MODE_DRAW: begin
        if (on_screen) begin
          r.in_range = 1'b1;
          frame_copy[addr][y[2:0]] = color ^ invert_q;
        end
      end
      MODE_FILL: begin
        r.in_range = 1'b1;
        for (int i = 0; i < STORE_DEPTH; i++) frame_copy[i] = color ? FILL_SET : FILL_CLEAR;
      end
      MODE_READ: begin
        if (on_screen) begin
          r.in_range  = 1'b1;
          r.read_byte = frame_copy[addr];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    pixel_resp_t exp_w;
    if (!rst_n) begin
      invert_q = 1'b0;
      expected_resp.delete();
      fails    = 0;
      checked  = 0;
      for (int i = 0; i < STORE_DEPTH; i++) frame_copy[i] = '0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == REG_INVERT_PIXELS) begin
        if (cfg_pwrite) begin
          invert_q = cfg_pwdata[0];
        end else if (cfg_prdata !== CFG_DATA_W'(invert_q)) begin
          fails++;
          if (fails <= REPORT_MAX)
            $display("[%0t] invert readback: expected %0h got %0h", $realtime, invert_q,
                     cfg_prdata);
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_resp.push_back(apply_command(in_ch.mode, in_ch.column, in_ch.row,
                                              in_ch.color));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_resp.size() == 0) begin
          fails++;
          if (fails <= REPORT_MAX)
            $display("[%0t] response word with nothing outstanding: byte %0h range %0b",
                     $realtime, out_ch.read_byte, out_ch.in_range);
        end else begin
          exp_w = expected_resp.pop_front();
          checked++;
          if (out_ch.read_byte !== exp_w.read_byte || out_ch.in_range !== exp_w.in_range) begin
            fails++;
            if (fails <= REPORT_MAX)
              $display("[%0t] mode %0d x %0d y %0d: expected byte %0h range %0b, got %0h %0b",
                       $realtime, exp_w.mode, exp_w.column, exp_w.row, exp_w.read_byte,
                       exp_w.in_range, out_ch.read_byte, out_ch.in_range);
          end
        end
      end
    end
    fail_count  <= fails;
    pending_cnt <= expected_resp.size();
    checked_cnt <= checked;
  end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the page-mode framebuffer: a directed pass over
// the corner pixels, fills, off-screen and unused commands, then random
// traffic of all modes at several invert settings with random idle bursts.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mpf_pkg::*;

  localparam int DISP_W      = 128;
  localparam int DISP_H      = 64;
  localparam int STALL_LIMIT = 6000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 230;
  localparam logic [MODE_W-1:0]     MODE_UNUSED   = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  int                    fail_count;
  int                    pending_cnt;
  int                    checked_cnt;
  int                    idle_cycles;
  bit                    quiet;
  int                    n_draw, n_read, n_fill, n_unused, n_off, n_settings;

  logic [CFG_DATA_W-1:0] invert_values [PHASES] =
    '{32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
      32'h0000_0002};

  mpf_in_if  in_ch ();
  mpf_out_if out_ch ();

  mono_page_framebuffer #(
    .DISPLAY_WIDTH  (DISP_W),
    .DISPLAY_HEIGHT (DISP_H)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  mpf_resp_check #(
    .DISPLAY_WIDTH  (DISP_W),
    .DISPLAY_HEIGHT (DISP_H)
  ) resp_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .fail_count  (fail_count),
    .pending_cnt (pending_cnt),
    .checked_cnt (checked_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // response side: random stall bursts, none once the run goes quiet
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // watchdog: cycles without any accepted word
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
    $display("mono_page_framebuffer test failed");
    $finish;
  end

  task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [COORD_W-1:0] x,
                          input logic [COORD_W-1:0] y, input logic color);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.mode   <= mode;
    in_ch.column <= x;
    in_ch.row    <= y;
    in_ch.color  <= color;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    case (mode)
      MODE_DRAW: n_draw++;
      MODE_READ: n_read++;
      MODE_FILL: n_fill++;
      default:   n_unused++;
    endcase
    if (mode != MODE_FILL && mode != MODE_UNUSED && (int'(x) >= DISP_W || int'(y) >= DISP_H))
      n_off++;
  endtask

  // hold off the sender until every outstanding response has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
  endtask

  task automatic reg_access(input logic write, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_invert(input logic [CFG_DATA_W-1:0] value);
    wait_drained();
    // let a pending write-back settle
    repeat (4) @(posedge clk);
    reg_access(1'b1, REG_INVERT_PIXELS, value);
    reg_access(1'b0, REG_INVERT_PIXELS, '0);
    n_settings++;
  endtask

  task automatic send_random();
    int unsigned        pick;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    pick = $urandom_range(0, 99);
    // half the on-screen draws and reads land in a small corner so reads see earlier draws
    if ($urandom_range(0, 1)) begin
      x = COORD_W'($urandom_range(0, 15));
      y = COORD_W'($urandom_range(0, 23));
    end else begin
      x = COORD_W'($urandom_range(0, DISP_W - 1));
      y = COORD_W'($urandom_range(0, DISP_H - 1));
    end
    if ($urandom_range(0, 99) == 0)
      wait_drained();
    if (pick < 45) begin
      send_cmd(MODE_DRAW, x, y, 1'($urandom_range(0, 1)));
    end else if (pick < 84) begin
      send_cmd(MODE_READ, x, y, 1'($urandom_range(0, 1)));
    end else if (pick < 86) begin
      send_cmd(MODE_FILL, COORD_W'($urandom_range(0, 255)), COORD_W'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)));
    end else if (pick < 91) begin
      send_cmd(MODE_UNUSED, COORD_W'($urandom_range(0, 255)), COORD_W'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)));
    end else begin
      if ($urandom_range(0, 1)) begin
        x = COORD_W'($urandom_range(DISP_W, 255));
        y = COORD_W'($urandom_range(0, 255));
      end else begin
        x = COORD_W'($urandom_range(0, 255));
        y = COORD_W'($urandom_range(DISP_H, 255));
      end
      send_cmd($urandom_range(0, 1) ? MODE_DRAW : MODE_READ, x, y, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    quiet         = 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.mode   <= MODE_DRAW;
    in_ch.column <= '0;
    in_ch.row    <= '0;
    in_ch.color  <= 1'b0;
    cfg_psel     <= 1'b0;
    cfg_penable  <= 1'b0;
    cfg_pwrite   <= 1'b0;
    cfg_paddr    <= '0;
    cfg_pwdata   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_invert(32'h0);
    // store is undefined until the first fill
    send_cmd(MODE_FILL, 8'd0, 8'd0, 1'b0);
    send_cmd(MODE_READ, 8'd0, 8'd0, 1'b0);
    send_cmd(MODE_DRAW, 8'd0, 8'd0, 1'b1);
    send_cmd(MODE_DRAW, 8'd127, 8'd63, 1'b1);
    send_cmd(MODE_DRAW, 8'd0, 8'd63, 1'b1);
    send_cmd(MODE_DRAW, 8'd127, 8'd0, 1'b1);
    send_cmd(MODE_READ, 8'd0, 8'd0, 1'b0);
    send_cmd(MODE_READ, 8'd127, 8'd63, 1'b0);
    send_cmd(MODE_READ, 8'd0, 8'd56, 1'b0);
    send_cmd(MODE_READ, 8'd127, 8'd7, 1'b0);
    // off-screen draws and reads, then unused-mode commands
    send_cmd(MODE_DRAW, 8'd128, 8'd0, 1'b1);
    send_cmd(MODE_DRAW, 8'd0, 8'd64, 1'b1);
    send_cmd(MODE_DRAW, 8'd255, 8'd255, 1'b1);
    send_cmd(MODE_READ, 8'd128, 8'd0, 1'b0);
    send_cmd(MODE_READ, 8'd255, 8'd255, 1'b1);
    send_cmd(MODE_UNUSED, 8'd0, 8'd0, 1'b1);
    send_cmd(MODE_UNUSED, 8'd255, 8'd255, 1'b0);
    send_cmd(MODE_READ, 8'd0, 8'd0, 1'b0);
    send_cmd(MODE_FILL, 8'd255, 8'd255, 1'b1);
    send_cmd(MODE_DRAW, 8'd64, 8'd32, 1'b0);
    send_cmd(MODE_READ, 8'd64, 8'd39, 1'b0);
    // inverted drawing; fill must ignore it
    set_invert(32'h1);
    send_cmd(MODE_DRAW, 8'd10, 8'd10, 1'b1);
    send_cmd(MODE_READ, 8'd10, 8'd8, 1'b0);
    send_cmd(MODE_FILL, 8'd0, 8'd0, 1'b0);
    send_cmd(MODE_DRAW, 8'd10, 8'd10, 1'b0);
    send_cmd(MODE_READ, 8'd10, 8'd10, 1'b0);
    wait_drained();
    repeat (4) @(posedge clk);
    reg_access(1'b1, UNMAPPED_ADDR, 32'hFFFF_FFFF);
    reg_access(1'b0, REG_INVERT_PIXELS, '0);

    for (int p = 0; p < PHASES; p++) begin
      set_invert(invert_values[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == PHASES - 1 && i == PHASE_ITEMS / 3)
          quiet = 1'b1;
        send_random();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("ran %0d draws, %0d reads, %0d fills, %0d unused-mode commands (%0d off-screen)",
             n_draw, n_read, n_fill, n_unused, n_off);
    $display("checked %0d responses across %0d invert register settings",
             checked_cnt, n_settings);
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("mono_page_framebuffer test passed");
    end else begin
      $display("mono_page_framebuffer test failed");
    end
    $finish;
  end

endmodule
